[rtl/core/nth_weekday_date_finder_unit_macros.svh]
// Assertion macros shared by the nth weekday date finder RTL
// Depends on nothing; included by the modules that carry assertions
`ifndef NTH_WEEKDAY_DATE_FINDER_UNIT_MACROS_SVH
`define NTH_WEEKDAY_DATE_FINDER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while in reset
`define NWD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define NWD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NWD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define NWD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/core/nwd_pkg.sv]
// Types, constants and calendar table functions of the nth weekday date finder
// Depends on nothing; used by the interfaces and all modules
package nwd_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int WDAY_W  = 3;
    localparam int ORD_W   = 7;
    localparam int DAY_W   = 5;

    // internal widths
    localparam int A_W    = 15;   // year plus bias
    localparam int Q_W    = 8;    // biased year / 100
    localparam int R_W    = 7;    // biased year % 100
    localparam int S_W    = 16;   // weekday sum before mod 7
    localparam int POS_W  = 11;   // signed day or day-of-year position
    localparam int PROD_W = 28;

    // year bias: y + 400 - 1, keeps the weekday and avoids a negative operand
    localparam logic [A_W-1:0] A_BIAS = 15'd399;

    // x / 100 == (x * 5243) >> 19 for x below 43699
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [A_W-1:0] HUNDRED  = 15'd100;

    // biased year % 100 of a year that is a multiple of 100
    localparam logic [R_W-1:0] R_CENTURY = 7'd99;

    localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

    localparam logic [WDAY_W-1:0] WD_SAT = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LEAP,
        ST_WDAY,
        ST_CALC,
        ST_WALK,
        ST_FIN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div;
        logic leap;
        logic wday;
        logic calc;
        logic walk;
        logic fin;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
    } dp_stat_t;

    // length of month m
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] n;
        begin
            unique case (m) inside
                4'd2:                   n = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
                default:                n = 5'd31;
            endcase
            return n;
        end
    endfunction

    // weekday offset of the first of month m, leap day included
    function automatic logic [3:0] month_off(input logic [MONTH_W-1:0] m,
                                             input logic leap);
        logic [3:0] off;
        begin
            unique case (m) inside
                4'd1, 4'd10:        off = 4'd0;
                4'd2, 4'd3, 4'd11:  off = 4'd3;
                4'd4, 4'd7:         off = 4'd6;
                4'd5:               off = 4'd1;
                4'd6:               off = 4'd4;
                4'd8:               off = 4'd2;
                4'd9, 4'd12:        off = 4'd5;
                default:            off = 4'd0;
            endcase
            if (m > M_FEB && leap)
                off = off + 4'd1;
            return off;
        end
    endfunction

    // x mod 7 by folding octal digits (8 == 1 mod 7)
    function automatic logic [2:0] mod7(input logic [S_W-1:0] x);
        logic [5:0] d;
        logic [3:0] e;
        begin
            d = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
              + 6'(x[14:12]) + 6'(x[15]);
            e = 4'(d[5:3]) + 4'(d[2:0]);
            return (e >= 4'd7) ? 3'(e - 4'd7) : e[2:0];
        end
    endfunction

endpackage

[rtl/core/nwd_if.sv]
// Request and result channel interfaces of the nth weekday date finder
// Depends on nwd_pkg
interface nwd_in_if;
    import nwd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [YEAR_W-1:0]        year;
    logic [MONTH_W-1:0]       month;
    logic [WDAY_W-1:0]        weekday;
    logic signed [ORD_W-1:0]  ordinal;

    modport source (output valid, command, year, month, weekday, ordinal, input ready);
    modport sink   (input valid, command, year, month, weekday, ordinal, output ready);
endinterface

interface nwd_out_if;
    import nwd_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;

    modport source (output valid, found, result_month, result_day, input ready);
    modport sink   (input valid, found, result_month, result_day, output ready);
endinterface

[rtl/core/nwd_ctrl.sv]
// Sequencing state machine of the nth weekday date finder
// Depends on nwd_pkg and the assertion macro header
`include "nth_weekday_date_finder_unit_macros.svh"

module nwd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  nwd_pkg::dp_stat_t stat,
    output nwd_pkg::dp_cmd_t  cmd
);
    import nwd_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   accept;

    assign slot_free = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_DIV;
            ST_DIV:  state_next = ST_LEAP;
            ST_LEAP: state_next = ST_WDAY;
            ST_WDAY: state_next = ST_CALC;
            ST_CALC: state_next = ST_WALK;
            ST_WALK: if (stat.walk_done) state_next = ST_FIN;
            ST_FIN:  if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath commands and ready
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:  cmd.div  = 1'b1;
            ST_LEAP: cmd.leap = 1'b1;
            ST_WDAY: cmd.wday = 1'b1;
            ST_CALC: cmd.calc = 1'b1;
            ST_WALK: cmd.walk = !stat.walk_done;
            ST_FIN:  cmd.fin  = slot_free;
            default: cmd      = '0;
        endcase
    end

    // result word valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `NWD_ASSERT_NXT(a_accept_starts, clk, rst_n, accept, state_reg == ST_DIV, "accepted word did not start the divide step")
    `NWD_ASSERT_NXT(a_walk_exits, clk, rst_n, state_reg == ST_WALK && stat.walk_done, state_reg == ST_FIN, "month walk did not finish")
    `NWD_ASSERT_NXT(a_fin_shows, clk, rst_n, cmd.fin, out_valid_reg && state_reg == ST_IDLE, "finished result not presented")

endmodule

[rtl/core/nwd_dp.sv]
// Datapath of the nth weekday date finder: year split, leap test,
// weekday of the first, occurrence position and month walk
// Depends on nwd_pkg and the assertion macro header
`include "nth_weekday_date_finder_unit_macros.svh"

module nwd_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nwd_pkg::dp_cmd_t               cmd,
    output nwd_pkg::dp_stat_t              stat,
    input  logic                           command,
    input  logic [nwd_pkg::YEAR_W-1:0]     year,
    input  logic [nwd_pkg::MONTH_W-1:0]    month,
    input  logic [nwd_pkg::WDAY_W-1:0]     weekday,
    input  logic signed [nwd_pkg::ORD_W-1:0] ordinal,
    output logic                           found,
    output logic [nwd_pkg::MONTH_W-1:0]    result_month,
    output logic [nwd_pkg::DAY_W-1:0]      result_day
);
    import nwd_pkg::*;

    // latched request
    logic                    cmd_reg;
    logic [MONTH_W-1:0]      month_reg;
    logic [WDAY_W-1:0]       wkd_reg;
    logic signed [ORD_W-1:0] ord_reg;
    logic [A_W-1:0]          a_reg;

    // intermediate results
    logic [Q_W-1:0]          q_reg;
    logic                    leap_reg;
    logic [S_W-1:0]          s_reg;
    logic [WDAY_W-1:0]       fw_reg;
    logic signed [POS_W-1:0] doy_reg;
    logic                    hit_reg;
    logic [MONTH_W-1:0]      m_reg;

    // result word
    logic                    found_reg;
    logic [MONTH_W-1:0]      rm_reg;
    logic [DAY_W-1:0]        rd_reg;

    logic [PROD_W-1:0]       prod;
    logic [A_W-1:0]          hund;
    logic [R_W-1:0]          r_c;
    logic                    leap_c;
    logic [S_W-1:0]          s_c;
    logic [MONTH_W-1:0]      msel_c;
    logic [DAY_W-1:0]        dim_sel;
    logic [3:0]              tt;
    logic [3:0]              tm;
    logic [DAY_W:0]          first_c;
    logic [DAY_W:0]          last_c;
    logic signed [POS_W-1:0] ord_ext;
    logic signed [POS_W-1:0] ord_p1;
    logic signed [POS_W-1:0] ord_m1;
    logic signed [POS_W-1:0] base_neg;
    logic signed [POS_W-1:0] val_c;
    logic signed [POS_W-1:0] lim_c;
    logic                    month_ok;
    logic                    hit_c;
    logic [DAY_W-1:0]        dim_walk;
    logic signed [POS_W-1:0] dim_walk_s;
    logic                    walk_done;

    // biased year / 100 by reciprocal multiply
    assign prod = PROD_W'(a_reg) * PROD_W'(RECIP100);

    // remainder, leap test and the weekday sum without the month offset
    assign hund   = A_W'(q_reg) * HUNDRED;
    assign r_c    = R_W'(a_reg - hund);
    assign leap_c = (r_c == R_CENTURY) ? (q_reg[1:0] == 2'b11) : (a_reg[1:0] == 2'b11);
    assign s_c    = S_W'(a_reg) + S_W'(1) + S_W'(a_reg[A_W-1:2])
                  - S_W'(q_reg) + S_W'(q_reg[Q_W-1:2]);

    // month whose first weekday matters
    assign msel_c = cmd_reg ? (ord_reg[ORD_W-1] ? M_DEC : M_JAN) : month_reg;

    // first and last occurrence of the weekday in the selected month
    assign dim_sel = days_in(msel_c, leap_reg);
    assign tt      = 4'(wkd_reg) + 4'd7 - 4'(fw_reg);
    assign tm      = (tt >= 4'd7) ? (tt - 4'd7) : tt;
    assign first_c = (DAY_W+1)'(tm) + (DAY_W+1)'(1);
    assign last_c  = (first_c + (DAY_W+1)'(28) > (DAY_W+1)'(dim_sel))
                   ? first_c + (DAY_W+1)'(21) : first_c + (DAY_W+1)'(28);

    // position of the requested occurrence
    assign ord_ext  = POS_W'(ord_reg);
    assign ord_p1   = ord_ext + 11'sd1;
    assign ord_m1   = ord_ext - 11'sd1;
    assign base_neg = cmd_reg ? (11'sd334 + $signed(POS_W'(leap_reg))) : 11'sd0;

    always_comb
    begin
        if (ord_reg[ORD_W-1])
            val_c = base_neg + $signed(POS_W'(last_c)) + ((ord_p1 <<< 3) - ord_p1);
        else
            val_c = $signed(POS_W'(first_c)) + ((ord_m1 <<< 3) - ord_m1);
    end

    assign month_ok = (month_reg >= M_JAN) && (month_reg <= M_DEC);
    assign lim_c    = cmd_reg ? (11'sd365 + $signed(POS_W'(leap_reg)))
                              : $signed(POS_W'(dim_sel));
    assign hit_c    = (ord_reg != '0) && (cmd_reg || month_ok)
                   && (val_c >= 11'sd1) && (val_c <= lim_c);

    // month walk for year scope
    assign dim_walk   = days_in(m_reg, leap_reg);
    assign dim_walk_s = $signed(POS_W'(dim_walk));
    assign walk_done  = !cmd_reg || !hit_reg || (m_reg == M_DEC) || (doy_reg <= dim_walk_s);
    assign stat.walk_done = walk_done;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            month_reg <= month;
            wkd_reg   <= (weekday > WD_SAT) ? '0 : weekday;
            ord_reg   <= ordinal;
            a_reg     <= A_W'(year) + A_BIAS;
        end
        if (cmd.div)
            q_reg <= prod[RECIP_SHIFT +: Q_W];
        if (cmd.leap)
        begin
            leap_reg <= leap_c;
            s_reg    <= s_c;
        end
        if (cmd.wday)
            fw_reg <= mod7(s_reg + S_W'(month_off(msel_c, leap_reg)));
        if (cmd.calc)
        begin
            doy_reg <= val_c;
            hit_reg <= hit_c;
            m_reg   <= cmd_reg ? M_JAN : month_reg;
        end
        else if (cmd.walk)
        begin
            doy_reg <= doy_reg - dim_walk_s;
            m_reg   <= m_reg + MONTH_W'(1);
        end
        if (cmd.fin)
        begin
            found_reg <= hit_reg;
            rm_reg    <= hit_reg ? m_reg : '0;
            rd_reg    <= hit_reg ? DAY_W'(doy_reg) : '0;
        end
    end

    assign found        = found_reg;
    assign result_month = rm_reg;
    assign result_day   = rd_reg;

    `NWD_ASSERT_NXT(a_hit_fields, clk, rst_n, cmd.fin && hit_reg, found_reg && rd_reg != '0 && rm_reg >= M_JAN && rm_reg <= M_DEC, "found date has bad month or day")
    `NWD_ASSERT_NXT(a_miss_zero, clk, rst_n, cmd.fin && !hit_reg, !found_reg && rm_reg == '0 && rd_reg == '0, "missing date not reported as zeros")
    `NWD_ASSERT_NXT(a_walk_positive, clk, rst_n, cmd.walk, doy_reg >= 11'sd1 && m_reg <= M_DEC, "month walk left the year")

endmodule

[rtl/core/nth_weekday_date_finder_unit.sv]
// Top level of the nth weekday date finder: controller plus datapath
// Depends on nwd_pkg, nwd_if, nwd_ctrl and nwd_dp
//
//   channel   dir   word fields
//   in_ch     in    command, year, month, weekday, ordinal
//   out_ch    out   found, result_month, result_day
//
// One request word at a time. Month scope: from acceptance to the next acceptance a
// word passes the steps accept, divide, leap, weekday, position, walk check, finish.
// Year scope adds one walk step for each month stepped, up to December at most.
// The result sits in an output register until taken; a stalled result holds the
// finish step, and a new word is accepted once the result register is loaded.
// Reset clears the state machine and the result valid flag; no clearing pass.
module nth_weekday_date_finder_unit (
    input  logic  clk,
    input  logic  rst_n,
    nwd_in_if.sink    in_ch,
    nwd_out_if.source out_ch
);
    import nwd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing
    nwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and result register
    nwd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .command      (in_ch.command),
        .year         (in_ch.year),
        .month        (in_ch.month),
        .weekday      (in_ch.weekday),
        .ordinal      (in_ch.ordinal),
        .found        (out_ch.found),
        .result_month (out_ch.result_month),
        .result_day   (out_ch.result_day)
    );

endmodule
